### design/pdb_pkg.sv
// Shared types, widths and constants for the point distance / bearing block.
// No dependencies; imported by pdb_distance, pdb_heading and point_distance_bearing.
package pdb_pkg;

	localparam int COORD_W  = 16;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int SQ_W     = 32;               // square of a 17-bit difference fits 32 bits
	localparam int SUM_W    = SQ_W + 1;
	localparam int RAD_W    = 42;               // (sum << 8) padded to an even width
	localparam int ROOT_W   = RAD_W / 2;
	localparam int REM_W    = ROOT_W + 3;
	localparam int SCALE_W  = 8;
	localparam int DIST_W   = 21;
	localparam int HEAD_W   = 16;
	localparam int ANGLE_W  = 32;
	localparam int PROD_W   = ANGLE_W + HEAD_W;
	localparam int VEC_W    = 28;               // covers CORDIC gain on 25-bit vectors
	localparam int ATAN_LEN = 24;

	// squares, sum, root stages, rounding, divider stages
	localparam int DIST_LAT = 2 + ROOT_W + 1 + DIST_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic [SCALE_W-1:0]        scale_t;
	typedef logic [DIST_W-1:0]         dist_t;
	typedef logic [HEAD_W-1:0]         head_t;

	localparam scale_t SCALE_RESET = 8'd11;

	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
	localparam head_t              HEADING_FULL = 16'd46080;

	// atan(2^-i) in binary angle units, 2^32 per turn
	localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

endpackage

### design/pdb_distance.sv
// Distance pipeline: squares, bit-per-stage square root, rounding, bit-per-stage divide.
// Depends on pdb_pkg. Every register advances only while en is high.
module pdb_distance (
	input  logic            clk,
	input  logic            en,
	input  pdb_pkg::scale_t scale,
	input  pdb_pkg::diff_t  dx,
	input  pdb_pkg::diff_t  dy,
	output pdb_pkg::dist_t  distance
);
	import pdb_pkg::*;

	logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
	logic [SQ_W-1:0]            sqx_s1, sqy_s1;
	logic [SUM_W-1:0]           sum;
	scale_t                     p_eff;

	logic [RAD_W-1:0]   rad_s  [ROOT_W+1];
	logic [REM_W-1:0]   rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0]  root_s [ROOT_W+1];
	logic [DIST_W-1:0]  wd_s   [DIST_W+1];
	logic [SCALE_W-1:0] drem_s [DIST_W+1];

	assign sqx_full = dx * dx;
	assign sqy_full = dy * dy;
	assign sum      = SUM_W'(sqx_s1) + SUM_W'(sqy_s1);
	assign p_eff    = (scale == '0) ? SCALE_W'(1) : scale;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1    <= sqx_full[SQ_W-1:0];
			sqy_s1    <= sqy_full[SQ_W-1:0];
			rad_s[0]  <= RAD_W'({sum, 8'b0});
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	// restoring square root, two radicand bits per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic [REM_W-1:0] trial, sub;
		logic             ge;
		always_comb begin
			trial = {rem_s[k][REM_W-3:0], rad_s[k][RAD_W-1 -: 2]};
			sub   = {1'b0, root_s[k], 2'b01};
			ge    = (trial >= sub);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][RAD_W-3:0], 2'b00};
				rem_s[k+1]  <= ge ? (trial - sub) : trial;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
			end
		end
	end

	// round half up before dividing
	always_ff @(posedge clk) begin
		if (en) begin
			wd_s[0]   <= root_s[ROOT_W] + DIST_W'(p_eff >> 1);
			drem_s[0] <= '0;
		end
	end

	// restoring divide by the scale; quotient bits shift in at the bottom
	for (genvar k = 0; k < DIST_W; k++) begin : g_div
		logic [SCALE_W:0] trial, dsub;
		logic             ge;
		always_comb begin
			trial = {drem_s[k], wd_s[k][DIST_W-1]};
			dsub  = {1'b0, p_eff};
			ge    = (trial >= dsub);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				drem_s[k+1] <= ge ? SCALE_W'(trial - dsub) : trial[SCALE_W-1:0];
				wd_s[k+1]   <= {wd_s[k][DIST_W-2:0], ge};
			end
		end
	end

	assign distance = wd_s[DIST_W];

endmodule

### design/pdb_heading.sv
// Heading pipeline: vectoring CORDIC in binary angle units, then scaling to 1/128 degree.
// Depends on pdb_pkg. Every register advances only while en is high.
module pdb_heading #(
	parameter int STEPS = 16
) (
	input  logic           clk,
	input  logic           en,
	input  pdb_pkg::diff_t dx,
	input  pdb_pkg::diff_t dy,
	output pdb_pkg::head_t heading
);
	import pdb_pkg::*;

	logic signed [VEC_W-1:0] xe, ye;
	logic                    neg;
	logic [ANGLE_W-1:0]      zu, h;
	logic [PROD_W:0]         rnd;
	logic [HEAD_W:0]         hq;
	logic [PROD_W-1:0]       prod_s;
	head_t                   head_s;

	logic signed [VEC_W-1:0] x_s    [STEPS+1];
	logic signed [VEC_W-1:0] y_s    [STEPS+1];
	logic [ANGLE_W-1:0]      z_s    [STEPS+1];
	logic                    zero_s [STEPS+1];

	assign xe  = {{(VEC_W-DIFF_W-8){dx[DIFF_W-1]}}, dx, 8'b0};
	assign ye  = {{(VEC_W-DIFF_W-8){dy[DIFF_W-1]}}, dy, 8'b0};
	assign neg = dx[DIFF_W-1];

	// fold the left half plane over by a half turn
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= neg ? -xe : xe;
			y_s[0]    <= neg ? -ye : ye;
			z_s[0]    <= neg ? HALF_TURN : '0;
			zero_s[0] <= (dx == '0) && (dy == '0);
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [VEC_W-1:0] xs, ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][VEC_W-1]) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + ATAN_TURNS[i];
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - ATAN_TURNS[i];
				end
			end
		end
	end

	// coincident points give angle zero
	assign zu = zero_s[STEPS] ? '0 : z_s[STEPS];
	assign h  = zu - QUARTER_TURN;

	assign rnd = {1'b0, prod_s} + (PROD_W+1)'(HALF_TURN);
	assign hq  = rnd[PROD_W -: HEAD_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s <= {{HEAD_W{1'b0}}, h} * {{ANGLE_W{1'b0}}, HEADING_FULL};
			head_s <= (hq >= {1'b0, HEADING_FULL}) ? '0 : hq[HEAD_W-1:0];
		end
	end

	assign heading = head_s;

endmodule

### design/point_distance_bearing.sv
// Point distance and bearing: top level with input differences, path alignment and
// the output skid entry. Depends on pdb_pkg, pdb_distance and pdb_heading.
//
// Usage:
//   Pair channel (pair_valid / pair_stall) takes start and end points in Q12.4 pixels.
//   Result channel (result_valid / result_stall) returns distance_nm in 1/256 nm and
//   heading in 1/128 degree, one result per pair, in order.
//   pixels_per_nm is written with pixels_per_nm_we / pixels_per_nm_data; the user must
//   write it only while idle, which the block does not enforce; zero acts as one.
//   Throughput: one pair per cycle while pair_stall is low. The distance path is the
//   longer one (21 square-root stages, one bit each, and 21 divider stages, one
//   quotient bit each). The heading path is delayed to match.
//   Reset clears the valid bits and the skid entry and loads pixels_per_nm with 11.
//   When the receiver stalls a waiting result, that result is parked in
//   a one-entry skid register; the pipeline then holds and pair_stall rises until the
//   parked transaction is taken. pair_stall is a register output.
module point_distance_bearing #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pair_valid,
	output logic            pair_stall,
	input  pdb_pkg::coord_t start_x,
	input  pdb_pkg::coord_t start_y,
	input  pdb_pkg::coord_t end_x,
	input  pdb_pkg::coord_t end_y,
	input  logic            pixels_per_nm_we,
	input  pdb_pkg::scale_t pixels_per_nm_data,
	output logic            result_valid,
	input  logic            result_stall,
	output pdb_pkg::dist_t  distance_nm,
	output pdb_pkg::head_t  heading
);
	import pdb_pkg::*;

	localparam int ANG_LAT = CORDIC_STEPS + 3;
	localparam int PAD     = DIST_LAT - ANG_LAT;
	localparam int TOTAL   = 1 + DIST_LAT;

	logic             en;
	logic [TOTAL-1:0] valid_s;
	diff_t            dx_s1, dy_s1;
	scale_t           pixels_per_nm_q;
	dist_t            dist_last;
	head_t            head_raw;
	head_t            head_dly_s [PAD];
	logic             skid_valid_q;
	dist_t            skid_dist_q;
	head_t            skid_head_q;

	assign en         = !skid_valid_q;
	assign pair_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_per_nm_q <= SCALE_RESET;
		end else if (pixels_per_nm_we) begin
			pixels_per_nm_q <= pixels_per_nm_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[TOTAL-2:0], pair_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DIFF_W'(start_x) - DIFF_W'(end_x);
			dy_s1 <= DIFF_W'(start_y) - DIFF_W'(end_y);
		end
	end

	pdb_distance u_distance (
		.clk      (clk),
		.en       (en),
		.scale    (pixels_per_nm_q),
		.dx       (dx_s1),
		.dy       (dy_s1),
		.distance (dist_last)
	);

	pdb_heading #(
		.STEPS (CORDIC_STEPS)
	) u_heading (
		.clk     (clk),
		.en      (en),
		.dx      (dx_s1),
		.dy      (dy_s1),
		.heading (head_raw)
	);

	// line up the heading with the longer distance path
	always_ff @(posedge clk) begin
		if (en) begin
			head_dly_s[0] <= head_raw;
		end
	end

	for (genvar k = 1; k < PAD; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				head_dly_s[k] <= head_dly_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			skid_valid_q <= result_stall;
		end else begin
			skid_valid_q <= valid_s[TOTAL-1] && result_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			skid_dist_q <= dist_last;
			skid_head_q <= head_dly_s[PAD-1];
		end
	end

	assign result_valid = skid_valid_q || valid_s[TOTAL-1];
	assign distance_nm  = skid_valid_q ? skid_dist_q : dist_last;
	assign heading      = skid_valid_q ? skid_head_q : head_dly_s[PAD-1];

	// pipeline holds while a transaction is parked
	a_hold_when_parked: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> $stable(valid_s))
		else $error("pipeline moved while skid entry was full");

	a_park_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(valid_s[TOTAL-1]) && $past(result_stall))
		else $error("skid entry filled without a stalled result");

	a_park_release: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !result_stall |=> !skid_valid_q)
		else $error("skid entry not released after transaction");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> heading < HEADING_FULL)
		else $error("heading out of range");

endmodule
